// ===== hdl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// SRTF turnaround simulator package
// Field widths, operation codes and the control and status structures that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int ARRIVAL_W    = 16;
   localparam int BURST_W      = 10;
   localparam int JOB_INDEX_W  = 5;
   localparam int TURNAROUND_W = 20;
   localparam int TOTAL_W      = 25;
   localparam int JOB_TOTAL_W  = 6;
   localparam int BEST_W       = 11;

   localparam logic [BEST_W-1:0] NO_JOB = {BEST_W{1'b1}};

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_RUN  = 1'b1;

   typedef struct packed {
      logic load;
      logic start_run;
      logic scan_issue;
      logic tick;
      logic emit_ld;
      logic emit_empty;
      logic clear_count;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic idx_last;
      logic all_done;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hdl/srtf_req_if.sv =====
// ----------------------------------------------------------------------------
// SRTF request channel
// Valid/ready channel that carries job loads and run requests.
// ----------------------------------------------------------------------------
interface srtf_req_if
   import srtf_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [ARRIVAL_W-1:0] arrival;
   logic [BURST_W-1:0]   burst;

   modport source (output valid, output action, output arrival, output burst, input ready);
   modport sink   (input valid, input action, input arrival, input burst, output ready);
endinterface

// ===== hdl/srtf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// SRTF response channel
// Valid/ready channel that carries one turnaround result per job.
// ----------------------------------------------------------------------------
interface srtf_rsp_if
   import srtf_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [JOB_INDEX_W-1:0]  job_index;
   logic [TURNAROUND_W-1:0] turnaround;
   logic [TOTAL_W-1:0]      total_turnaround;
   logic [JOB_TOTAL_W-1:0]  job_total;
   logic                    last;

   modport source (output valid, output job_index, output turnaround,
                   output total_turnaround, output job_total, output last, input ready);
   modport sink   (input valid, input job_index, input turnaround,
                   input total_turnaround, input job_total, input last, output ready);
endinterface

// ===== hdl/srtf_dpath.sv =====
// ----------------------------------------------------------------------------
// SRTF datapath
// Job stores, scan comparator, tick update, turnaround accumulation and the
// response output register.
// ----------------------------------------------------------------------------
module srtf_dpath
   import srtf_pkg::*;
#(
   parameter int MAX_JOBS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           status,
   input  logic [ARRIVAL_W-1:0]    req_arrival,
   input  logic [BURST_W-1:0]      req_burst,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [JOB_INDEX_W-1:0]  rsp_job_index,
   output logic [TURNAROUND_W-1:0] rsp_turnaround,
   output logic [TOTAL_W-1:0]      rsp_total_turnaround,
   output logic [JOB_TOTAL_W-1:0]  rsp_job_total,
   output logic                    rsp_last
);

   localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW = $clog2(MAX_JOBS + 1);

   logic [ARRIVAL_W-1:0]    arrival_mem [MAX_JOBS];
   logic [BURST_W-1:0]      remaining_mem [MAX_JOBS];
   logic [TURNAROUND_W-1:0] turnaround_mem [MAX_JOBS];

   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           done_ff, done_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [TURNAROUND_W-1:0] sim_time_ff, sim_time_in;
   logic [IW-1:0]           running_ff, running_in;
   logic [BEST_W-1:0]       best_ff, best_in;
   logic [ARRIVAL_W-1:0]    run_arr_ff, run_arr_in;
   logic                    cmp_vld_ff;
   logic [IW-1:0]           cmp_idx_ff;
   logic [ARRIVAL_W-1:0]    arr_rd_ff;
   logic [BURST_W-1:0]      rem_rd_ff;
   logic [TURNAROUND_W-1:0] ta_rd_ff;
   logic [TOTAL_W-1:0]      total_ff, total_in;

   logic                    rsp_valid_ff;
   logic [JOB_INDEX_W-1:0]  rsp_job_index_ff;
   logic [TURNAROUND_W-1:0] rsp_turnaround_ff;
   logic [TOTAL_W-1:0]      rsp_total_ff;
   logic [JOB_TOTAL_W-1:0]  rsp_job_total_ff;
   logic                    rsp_last_ff;

   logic                    full;
   logic                    load_ok;
   logic                    hit;
   logic                    job_active;
   logic                    job_finish;
   logic [TOTAL_W-1:0]      total_sum;
   logic [31:0]             idx_wide;
   logic [31:0]             count_wide;
   logic                    rem_we;
   logic [IW-1:0]           rem_addr;
   logic [BURST_W-1:0]      rem_wdata;
   logic [TURNAROUND_W-1:0] ta_wdata;

   function automatic logic [BURST_W-1:0] rem_wdata_dec(input logic [BEST_W-1:0] b);
      logic [BEST_W-1:0] d;
      d = b - BEST_W'(1);
      return d[BURST_W-1:0];
   endfunction

   assign full       = (count_ff == CW'(MAX_JOBS));
   assign load_ok    = cmd.load && !full;
   assign job_active = (best_ff != NO_JOB);
   assign job_finish = (best_ff == BEST_W'(1));
   assign total_sum  = total_ff + TOTAL_W'(ta_rd_ff);
   assign idx_wide   = 32'(idx_ff);
   assign count_wide = 32'(count_ff);

   assign hit = cmp_vld_ff && ({{(TURNAROUND_W-ARRIVAL_W){1'b0}}, arr_rd_ff} <= sim_time_ff)
                && (rem_rd_ff != '0) && ({1'b0, rem_rd_ff} < best_ff);

   assign status.count_zero = (count_ff == '0);
   assign status.idx_last   = (CW'(idx_ff) == (count_ff - CW'(1)));
   assign status.all_done   = job_finish && ((done_ff + CW'(1)) == count_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rem_we    = load_ok || (cmd.tick && job_active);
   assign rem_addr  = load_ok ? count_ff[IW-1:0] : running_ff;
   assign rem_wdata = load_ok ? ((req_burst == '0) ? BURST_W'(1) : req_burst)
                              : rem_wdata_dec(best_ff);
   assign ta_wdata  = (sim_time_ff + TURNAROUND_W'(1))
                      - {{(TURNAROUND_W-ARRIVAL_W){1'b0}}, run_arr_ff};

   always_ff @(posedge clock) begin
      if (load_ok) begin
         arrival_mem[count_ff[IW-1:0]] <= req_arrival;
      end
      arr_rd_ff <= arrival_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         remaining_mem[rem_addr] <= rem_wdata;
      end
      rem_rd_ff <= remaining_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.tick && job_finish) begin
         turnaround_mem[running_ff] <= ta_wdata;
      end
      ta_rd_ff <= turnaround_mem[idx_ff];
   end

   always_comb begin
      count_in    = count_ff;
      done_in     = done_ff;
      idx_in      = idx_ff;
      sim_time_in = sim_time_ff;
      running_in  = running_ff;
      best_in     = best_ff;
      run_arr_in  = run_arr_ff;
      total_in    = total_ff;

      if (load_ok) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.start_run) begin
         done_in     = '0;
         idx_in      = '0;
         sim_time_in = '0;
         running_in  = '0;
         best_in     = NO_JOB;
         total_in    = '0;
      end
      if (cmd.scan_issue && !status.idx_last) begin
         idx_in = idx_ff + IW'(1);
      end
      if (hit) begin
         best_in    = {1'b0, rem_rd_ff};
         running_in = cmp_idx_ff;
         run_arr_in = arr_rd_ff;
      end
      if (cmd.tick) begin
         idx_in      = '0;
         sim_time_in = sim_time_ff + TURNAROUND_W'(1);
         if (job_finish) begin
            done_in = done_ff + CW'(1);
            best_in = NO_JOB;
         end else if (job_active) begin
            best_in = best_ff - BEST_W'(1);
         end
      end
      if (cmd.emit_ld) begin
         total_in = total_sum;
         if (!status.idx_last) begin
            idx_in = idx_ff + IW'(1);
         end
      end
      if (cmd.clear_count) begin
         count_in = '0;
         done_in  = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         done_ff     <= '0;
         idx_ff      <= '0;
         sim_time_ff <= '0;
         running_ff  <= '0;
         best_ff     <= NO_JOB;
         cmp_vld_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         done_ff     <= done_in;
         idx_ff      <= idx_in;
         sim_time_ff <= sim_time_in;
         running_ff  <= running_in;
         best_ff     <= best_in;
         cmp_vld_ff  <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      run_arr_ff <= run_arr_in;
      total_ff   <= total_in;
      cmp_idx_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_ld || cmd.emit_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ld) begin
         rsp_job_index_ff  <= idx_wide[JOB_INDEX_W-1:0];
         rsp_turnaround_ff <= ta_rd_ff;
         rsp_total_ff      <= status.idx_last ? total_sum : '0;
         rsp_job_total_ff  <= count_wide[JOB_TOTAL_W-1:0];
         rsp_last_ff       <= status.idx_last;
      end else if (cmd.emit_empty) begin
         rsp_job_index_ff  <= '0;
         rsp_turnaround_ff <= '0;
         rsp_total_ff      <= '0;
         rsp_job_total_ff  <= '0;
         rsp_last_ff       <= 1'b1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_job_index        = rsp_job_index_ff;
   assign rsp_turnaround       = rsp_turnaround_ff;
   assign rsp_total_turnaround = rsp_total_ff;
   assign rsp_job_total        = rsp_job_total_ff;
   assign rsp_last             = rsp_last_ff;

   // A result must never overwrite one that has not yet been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_ld || cmd.emit_empty) |-> status.out_free)
      else $error("Response register overwritten while a transaction is pending.");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (CW'(cmp_idx_ff) < count_ff))
      else $error("Scan compared a job beyond the loaded count.");

   a_running_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && job_active) |-> (CW'(running_ff) < count_ff))
      else $error("Running job lies beyond the loaded count.");

   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      done_ff <= count_ff)
      else $error("Finished job count exceeds the loaded count.");

endmodule

// ===== hdl/srtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// SRTF controller
// Sequences loads, the per-tick scan and update, and the result emission.
// ----------------------------------------------------------------------------
module srtf_ctrl
   import srtf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_action,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SCAN    = 7'b0000010,
      ST_DRAIN   = 7'b0000100,
      ST_TICK    = 7'b0001000,
      ST_EMIT_RD = 7'b0010000,
      ST_EMIT_LD = 7'b0100000,
      ST_EMPTY   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACTION_LOAD) begin
                  cmd.load = 1'b1;
               end else if (status.count_zero) begin
                  state_in = ST_EMPTY;
               end else begin
                  cmd.start_run = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_TICK;
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = status.all_done ? ST_EMIT_RD : ST_SCAN;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (status.out_free) begin
               cmd.emit_ld = 1'b1;
               if (status.idx_last) begin
                  cmd.clear_count = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/srtf_turnaround_sim_unit.sv =====
// ----------------------------------------------------------------------------
// SRTF turnaround simulator
// A load transaction stores one job unless the job store is full. A run
// transaction simulates preemptive shortest-remaining-time-first scheduling:
// each simulated tick scans the job store, whose single read port serves one
// job per cycle, then passes a drain state and an update state; idle ticks
// before the first arrival cost the same. Once every job has finished,
// results leave in load order through a read and an output state, the latter
// waiting for a free response register, and the last carries the total
// turnaround. A run with no jobs loaded returns one all-zero result marked last.
// ----------------------------------------------------------------------------
module srtf_turnaround_sim_unit
   import srtf_pkg::*;
#(
   parameter int MAX_JOBS = 32
) (
   input logic      clock,
   input logic      reset,
   srtf_req_if.sink   req_if,
   srtf_rsp_if.source rsp_if
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   srtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .status     (status),
      .cmd        (cmd)
   );

   srtf_dpath #(
      .MAX_JOBS (MAX_JOBS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_arrival          (req_if.arrival),
      .req_burst            (req_if.burst),
      .rsp_ready            (rsp_if.ready),
      .rsp_valid            (rsp_if.valid),
      .rsp_job_index        (rsp_if.job_index),
      .rsp_turnaround       (rsp_if.turnaround),
      .rsp_total_turnaround (rsp_if.total_turnaround),
      .rsp_job_total        (rsp_if.job_total),
      .rsp_last             (rsp_if.last)
   );

endmodule
